// ===== sv/tcpq_pkg.sv =====
// Package for the two-class priority queue: word types, codes and defaults.
// Depends on nothing; the unit and the core import it.
`default_nettype none

package tcpq_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int TICKET_BITS_DEFAULT = 16;
    localparam int TICKET_W            = 16;
    localparam int AGE_W               = 7;
    localparam int COUNT_W             = 5;
    localparam logic [AGE_W-1:0] THRESHOLD_RESET = 7'd60;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_MARK    = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                 operation;
        logic [TICKET_W-1:0] ticket;
        logic [AGE_W-1:0]    age;
        logic                health_worker;
    } in_word_t;

    typedef struct packed {
        status_t             status;
        logic [TICKET_W-1:0] out_ticket;
        logic [AGE_W-1:0]    out_age;
        logic                out_priority;
        logic                out_emergency;
        logic [COUNT_W-1:0]  entry_count;
    } out_word_t;

endpackage

`default_nettype wire

// ===== sv/two_class_priority_queue_unit.sv =====
// Two-class priority queue. Words arrive on the in channel (valid/ready) as an
// operation: enqueue, dequeue head, mark emergency by ticket, remove by ticket.
// Each accepted word yields exactly one result word on the out channel
// (valid/ready) with a status, the returned entry and the entry count.
// Priority entries (age at or above the threshold, health workers, emergencies)
// sit ahead of normal ones; each class keeps arrival order.
// The threshold register is written on the cfg channel (valid/ready, always
// ready) and resets to 60. Write it only while the queue is idle.
// One word is in work at a time. All slot moves go through a single slot
// memory with one write and one registered read port, a read step and then
// a write or check step per slot. An enqueue shifts each entry behind the
// insert point; dequeue and remove scan every entry; marking scans every
// entry and also shifts the entries between the priority section's end and
// a normal entry that it lifts into that section. A full or empty rejection
// skips the memory. in_ready rises with out_valid.
// If the receiver stalls with a result still held, the next word finishes
// but waits in the core until the output register frees.
// Reset empties the queue at once; slot contents are not cleared.
// Depends on tcpq_pkg and tcpq_core.
`default_nettype none

module two_class_priority_queue_unit #(
    parameter int DEPTH       = tcpq_pkg::DEPTH_DEFAULT,
    parameter int TICKET_BITS = tcpq_pkg::TICKET_BITS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tcpq_pkg::AGE_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tcpq_pkg::in_word_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output tcpq_pkg::out_word_t              out_data
);

    import tcpq_pkg::*;

    logic [AGE_W-1:0] threshold_reg;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg;
    logic             core_idle;
    logic             core_done;
    logic             core_ack;
    out_word_t        core_result;

    tcpq_core #(
        .DEPTH       (DEPTH),
        .TICKET_BITS (TICKET_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid & core_idle),
        .in_word   (in_data),
        .idle      (core_idle),
        .threshold (threshold_reg),
        .done      (core_done),
        .ack       (core_ack),
        .result    (core_result)
    );

    assign core_ack       = core_done & (~out_valid_reg | out_ready);
    assign out_valid_next = core_ack | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                threshold_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_ack)
        begin
            out_data_reg <= core_result;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = core_idle;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/tcpq_slot_mem.sv =====
// Slot memory of the queue: one write port and one registered read port.
// Depends on nothing outside this file.
`default_nettype none

module tcpq_slot_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 25
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcpq_core.sv =====
// Sequencer of the queue: walks the slot memory one slot per step to insert,
// shift, compact and mark entries. Depends on tcpq_pkg and tcpq_slot_mem.
`default_nettype none

module tcpq_core #(
    parameter int DEPTH       = tcpq_pkg::DEPTH_DEFAULT,
    parameter int TICKET_BITS = tcpq_pkg::TICKET_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire tcpq_pkg::in_word_t            in_word,
    output logic                               idle,
    input  wire logic [tcpq_pkg::AGE_W-1:0]    threshold,
    output logic                               done,
    input  wire logic                          ack,
    output tcpq_pkg::out_word_t                result
);

    import tcpq_pkg::*;

    localparam int TW = (TICKET_BITS < TICKET_W) ? TICKET_BITS : TICKET_W;
    localparam int EW = TW + AGE_W + 2;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    status_t          status_reg, status_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    pc_reg, pc_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    stop_reg, stop_next;
    logic [TW-1:0]    tk_reg, tk_next;
    logic             found_reg, found_next;
    logic [EW-1:0]    put_reg, put_next;
    logic [TW-1:0]    res_tk_reg, res_tk_next;
    logic [AGE_W-1:0] res_age_reg, res_age_next;
    logic             res_pri_reg, res_pri_next;
    logic             res_emg_reg, res_emg_next;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;

    logic [TW-1:0]    rd_tk;
    logic             rd_pri;
    logic             match;
    logic             new_pri;
    logic [CW-1:0]    new_stop;
    logic [CW-1:0]    j_less;

    tcpq_slot_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign rd_tk    = rd_data[EW-1 -: TW];
    assign rd_pri   = rd_data[1];
    assign match    = (op_reg == OP_DEQUEUE) ? (i_reg == '0) : (rd_tk == tk_reg);
    assign new_pri  = (in_word.age >= threshold) | in_word.health_worker;
    assign new_stop = new_pri ? pc_reg : n_reg;
    assign j_less   = j_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            pc_reg    <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        status_reg  <= status_next;
        i_reg       <= i_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        stop_reg    <= stop_next;
        tk_reg      <= tk_next;
        found_reg   <= found_next;
        put_reg     <= put_next;
        res_tk_reg  <= res_tk_next;
        res_age_reg <= res_age_next;
        res_pri_reg <= res_pri_next;
        res_emg_reg <= res_emg_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        n_next       = n_reg;
        pc_next      = pc_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        stop_next    = stop_reg;
        tk_next      = tk_reg;
        found_next   = found_reg;
        put_next     = put_reg;
        res_tk_next  = res_tk_reg;
        res_age_next = res_age_reg;
        res_pri_next = res_pri_reg;
        res_emg_next = res_emg_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = rd_data;
        done         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = in_word.operation;
                    tk_next      = in_word.ticket[TW-1:0];
                    status_next  = ST_OK;
                    found_next   = 1'b0;
                    res_tk_next  = '0;
                    res_age_next = '0;
                    res_pri_next = 1'b0;
                    res_emg_next = 1'b0;
                    i_next       = '0;
                    k_next       = '0;
                    if (in_word.operation == OP_ENQUEUE)
                    begin
                        if (n_reg == CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            put_next   = {in_word.ticket[TW-1:0], in_word.age, new_pri, 1'b0};
                            stop_next  = new_stop;
                            j_next     = n_reg;
                            state_next = (n_reg > new_stop) ? S_SHIFT_RD : S_PUT;
                        end
                    end
                    else if (n_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SHIFT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_less[AW-1:0];
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_data    = rd_data;
                j_next     = j_less;
                state_next = (j_less > stop_reg) ? S_SHIFT_RD : S_PUT;
            end

            S_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = stop_reg[AW-1:0];
                wr_data = put_reg;
                if (op_reg == OP_ENQUEUE)
                begin
                    n_next     = n_reg + 1'b1;
                    pc_next    = pc_reg + CW'(put_reg[1]);
                    state_next = S_DONE;
                end
                else
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                if (i_reg < n_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    if (op_reg != OP_MARK)
                    begin
                        n_next = k_reg;
                    end
                    if (op_reg != OP_DEQUEUE && !found_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
            end

            S_SCAN_CHK:
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_SCAN_RD;
                if (op_reg == OP_MARK)
                begin
                    if (match)
                    begin
                        found_next = 1'b1;
                        if (rd_pri)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = i_reg[AW-1:0];
                            wr_data = {rd_data[EW-1:1], 1'b1};
                        end
                        else
                        begin
                            // A normal match moves to the end of the priority section.
                            put_next   = {rd_data[EW-1:2], 2'b11};
                            stop_next  = pc_reg;
                            j_next     = i_reg;
                            state_next = (i_reg > pc_reg) ? S_SHIFT_RD : S_PUT;
                        end
                    end
                end
                else
                begin
                    if (match)
                    begin
                        found_next   = 1'b1;
                        res_tk_next  = rd_tk;
                        res_age_next = rd_data[AGE_W+1:2];
                        res_pri_next = rd_pri;
                        res_emg_next = rd_data[0];
                        if (rd_pri)
                        begin
                            pc_next = pc_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = k_reg[AW-1:0];
                        wr_data = rd_data;
                        k_next  = k_reg + 1'b1;
                    end
                end
            end

            S_DONE:
            begin
                done = 1'b1;
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle                 = (state_reg == S_IDLE);
    assign result.status        = status_reg;
    assign result.out_ticket    = TICKET_W'(res_tk_reg);
    assign result.out_age       = res_age_reg;
    assign result.out_priority  = res_pri_reg;
    assign result.out_emergency = res_emg_reg;
    assign result.entry_count   = COUNT_W'(n_reg);

endmodule

`default_nettype wire
